>>> design/mhl_pkg.sv
// mhl_pkg: shared types and constants for the loss and gradient engine
// no dependencies; used by design/mse_huber_loss_gradient.sv

package mhl_pkg;

	// fixed field widths
	localparam int ACC_W   = 48;
	localparam int VL_W    = 9;
	localparam int GRAD_W  = 18;
	localparam int MEAN_W  = 32;
	localparam int CFG_IDX_W = 1;

	// serial divider: dividend register holds the halved accumulator
	localparam int DIV_W   = ACC_W - 1;
	localparam int CNT_W   = $clog2(DIV_W + 1);

	// Q8.8 one, huber knee and gradient limits
	localparam int HUBER_ONE  = 256;
	localparam int HUBER_HALF = 128;
	localparam int HUBER_SHL  = 9;
	localparam int MSE_BIG_SH = 24;
	localparam int GRAD_LIM   = 131072;
	localparam logic [GRAD_W-1:0] GRAD_POS_MAX = 18'h1FFFF;
	localparam logic [VL_W:0]     COUNT_SAT    = 10'd511;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b1;

	// loss modes
	localparam logic MODE_MSE   = 1'b0;
	localparam logic MODE_HUBER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_ACC,
		ST_MEAN,
		ST_FIN
	} state_t;

endpackage

>>> design/mse_huber_loss_gradient.sv
// mse_huber_loss_gradient: mean squared / huber loss with per-element gradient
// depends on design/mhl_pkg.sv

// One element is taken per transfer and yields one result; the next is taken
// only once it is through: the accept, DATA_WIDTH+2 steps of the restoring
// divider that forms the gradient quotient one bit per cycle (the shift-add
// squarer runs alongside), an accumulate state and an output load state. The
// element marked last adds 47 further divider steps that form the mean loss. A
// finished result waits in the output register while the next element is
// accepted. Configuration is to be written through the cfg channel while the
// block is idle, a rule on the user that the block itself does not enforce.

module mse_huber_loss_gradient #(
	parameter int MAX_LENGTH = 256,
	parameter int DATA_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mhl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mhl_pkg::VL_W-1:0]            cfg_data,
	// element input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [DATA_WIDTH-1:0]        predicted_value,
	input  logic signed [DATA_WIDTH-1:0]        expected_value,
	input  logic                                negate_gradient,
	input  logic                                last_element,
	// result output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [mhl_pkg::GRAD_W-1:0]   gradient_value,
	output logic [mhl_pkg::MEAN_W-1:0]          mean_loss,
	output logic                                loss_valid,
	output logic                                length_error
);

	localparam int MAG_W  = DATA_WIDTH + 1;
	localparam int GM_W   = MAG_W + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int TERM_W = PROD_W + 1;
	localparam int SUM_W  = ((TERM_W > mhl_pkg::ACC_W) ? TERM_W : mhl_pkg::ACC_W) + 1;
	localparam int GQ_W   = (GM_W > mhl_pkg::GRAD_W) ? GM_W : mhl_pkg::GRAD_W;

	mhl_pkg::state_t state_q, state_d;

	logic                        mode_q;
	logic [mhl_pkg::VL_W-1:0]    vl_q;
	logic [mhl_pkg::VL_W-1:0]    len;

	logic [mhl_pkg::ACC_W-1:0]   acc_q;
	logic [mhl_pkg::VL_W-1:0]    elem_q;

	logic [MAG_W-1:0]            mag_q;
	logic                        dneg_q, neg_q, last_q, lerr_q;
	logic [PROD_W-1:0]           prod_q;
	logic [mhl_pkg::DIV_W-1:0]   quo_q;
	logic [mhl_pkg::VL_W-1:0]    rem_q;
	logic [mhl_pkg::CNT_W-1:0]   cnt_q;
	logic [mhl_pkg::GRAD_W-1:0]  grad_q;

	logic                        out_valid_q;
	logic [mhl_pkg::GRAD_W-1:0]  out_grad_q;
	logic [mhl_pkg::MEAN_W-1:0]  out_mean_q;
	logic                        out_lv_q, out_le_q;

	// control from the sequencer
	logic in_fire, calc_step, calc_done, mean_done, load_out;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == mhl_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mhl_pkg::MODE_MSE;
			vl_q   <= mhl_pkg::VL_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mhl_pkg::REG_LOSS_MODE:     mode_q <= cfg_data[0];
				mhl_pkg::REG_VECTOR_LENGTH: vl_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective length: zero reads as one, clamp at the maximum
	always_comb begin
		if (vl_q == '0)
			len = mhl_pkg::VL_W'(1);
		else if (32'(vl_q) > 32'(MAX_LENGTH))
			len = mhl_pkg::VL_W'(MAX_LENGTH);
		else
			len = vl_q;
	end

	// difference, magnitude and gradient magnitude of the incoming element
	logic [MAG_W-1:0] diff_u, mag_in;
	logic [GM_W-1:0]  gmag_in;
	always_comb begin
		diff_u = MAG_W'({predicted_value[DATA_WIDTH-1], predicted_value})
			- MAG_W'({expected_value[DATA_WIDTH-1], expected_value});
		mag_in = diff_u[MAG_W-1] ? (~diff_u + 1'b1) : diff_u;
		if (mode_q == mhl_pkg::MODE_MSE)
			gmag_in = {mag_in, 1'b0};
		else if (mag_in < MAG_W'(mhl_pkg::HUBER_ONE))
			gmag_in = {1'b0, mag_in};
		else
			gmag_in = GM_W'(mhl_pkg::HUBER_ONE);
	end

	// one restoring divider step, shared by gradient and mean
	logic [mhl_pkg::VL_W:0]   trial, trial_sub;
	logic                     trial_ge;
	logic [mhl_pkg::VL_W-1:0] rem_next;
	always_comb begin
		trial     = {rem_q, quo_q[mhl_pkg::DIV_W-1]};
		trial_ge  = trial >= {1'b0, len};
		trial_sub = trial - {1'b0, len};
		rem_next  = trial_ge ? trial_sub[mhl_pkg::VL_W-1:0] : trial[mhl_pkg::VL_W-1:0];
	end

	// one shift-add squarer step
	logic [MAG_W:0] prod_add;
	assign prod_add = {1'b0, prod_q[PROD_W-1:MAG_W]} + (prod_q[0] ? {1'b0, mag_q} : '0);

	// loss term and saturating accumulate
	logic [SUM_W-1:0]        term, sum;
	logic [mhl_pkg::ACC_W-1:0] acc_next;
	logic                    mag_big;
	always_comb begin
		mag_big = (mag_q >> mhl_pkg::MSE_BIG_SH) != '0;
		if (mode_q == mhl_pkg::MODE_MSE)
			term = mag_big ? SUM_W'({mhl_pkg::ACC_W{1'b1}}) : SUM_W'({prod_q, 1'b0});
		else if (mag_q < MAG_W'(mhl_pkg::HUBER_ONE))
			term = SUM_W'(prod_q);
		else
			term = SUM_W'(mag_q - MAG_W'(mhl_pkg::HUBER_HALF)) << mhl_pkg::HUBER_SHL;
		sum = SUM_W'(acc_q) + term;
		if (sum > SUM_W'({mhl_pkg::ACC_W{1'b1}}))
			acc_next = {mhl_pkg::ACC_W{1'b1}};
		else
			acc_next = sum[mhl_pkg::ACC_W-1:0];
	end

	// signed, saturated gradient from the quotient
	logic [GQ_W-1:0]           gq_x;
	logic [mhl_pkg::GRAD_W-1:0] gq_s, grad_next;
	always_comb begin
		gq_x = GQ_W'(quo_q[GM_W-1:0]);
		if (gq_x > GQ_W'(mhl_pkg::GRAD_LIM))
			gq_x = GQ_W'(mhl_pkg::GRAD_LIM);
		gq_s = gq_x[mhl_pkg::GRAD_W-1:0];
		if (dneg_q != neg_q)
			grad_next = ~gq_s + 1'b1;
		else if (gq_s[mhl_pkg::GRAD_W-1])
			grad_next = mhl_pkg::GRAD_POS_MAX;
		else
			grad_next = gq_s;
	end

	// length check on the last element
	logic [mhl_pkg::VL_W:0] count;
	assign count = {1'b0, elem_q} + 1'b1;

	// mean from the divider, saturated
	logic [mhl_pkg::MEAN_W-1:0] mean_sat;
	assign mean_sat = (quo_q[mhl_pkg::DIV_W-1:mhl_pkg::MEAN_W] != '0)
		? {mhl_pkg::MEAN_W{1'b1}} : quo_q[mhl_pkg::MEAN_W-1:0];

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mhl_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and step controls
	always_comb begin
		state_d   = state_q;
		calc_step = 1'b0;
		calc_done = 1'b0;
		mean_done = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			mhl_pkg::ST_IDLE: begin
				if (in_fire)
					state_d = mhl_pkg::ST_CALC;
			end
			mhl_pkg::ST_CALC: begin
				calc_step = 1'b1;
				calc_done = (cnt_q == mhl_pkg::CNT_W'(GM_W - 1));
				if (calc_done)
					state_d = mhl_pkg::ST_ACC;
			end
			mhl_pkg::ST_ACC: begin
				state_d = last_q ? mhl_pkg::ST_MEAN : mhl_pkg::ST_FIN;
			end
			mhl_pkg::ST_MEAN: begin
				mean_done = (cnt_q == mhl_pkg::CNT_W'(mhl_pkg::DIV_W - 1));
				if (mean_done)
					state_d = mhl_pkg::ST_FIN;
			end
			mhl_pkg::ST_FIN: begin
				load_out = !out_valid_q || out_ready;
				if (load_out)
					state_d = mhl_pkg::ST_IDLE;
			end
			default: state_d = mhl_pkg::ST_IDLE;
		endcase
	end

	// loss state: accumulator and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			elem_q <= '0;
		end else if (state_q == mhl_pkg::ST_ACC) begin
			if (last_q) begin
				acc_q  <= '0;
				elem_q <= '0;
			end else begin
				acc_q <= acc_next;
				if ({1'b0, elem_q} < mhl_pkg::COUNT_SAT)
					elem_q <= elem_q + 1'b1;
			end
		end
	end

	// element datapath: squarer, divider, gradient
	always_ff @(posedge clk) begin
		priority if (in_fire) begin
			mag_q  <= mag_in;
			dneg_q <= diff_u[MAG_W-1];
			neg_q  <= negate_gradient;
			last_q <= last_element;
			prod_q <= {{MAG_W{1'b0}}, mag_in};
			quo_q  <= mhl_pkg::DIV_W'(gmag_in) << (mhl_pkg::DIV_W - GM_W);
			rem_q  <= '0;
			cnt_q  <= '0;
		end else if (calc_step || state_q == mhl_pkg::ST_MEAN) begin
			quo_q <= {quo_q[mhl_pkg::DIV_W-2:0], trial_ge};
			rem_q <= rem_next;
			cnt_q <= cnt_q + 1'b1;
			if (calc_step && cnt_q < mhl_pkg::CNT_W'(MAG_W))
				prod_q <= {prod_add, prod_q[MAG_W-1:1]};
		end else if (state_q == mhl_pkg::ST_ACC) begin
			grad_q <= grad_next;
			lerr_q <= (count != {1'b0, len});
			// halved accumulator feeds the mean division
			quo_q  <= acc_next[mhl_pkg::ACC_W-1:1];
			rem_q  <= '0;
			cnt_q  <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_grad_q <= grad_q;
			out_mean_q <= last_q ? mean_sat : '0;
			out_lv_q   <= last_q;
			out_le_q   <= last_q && lerr_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign gradient_value = $signed(out_grad_q);
	assign mean_loss      = out_mean_q;
	assign loss_valid     = out_lv_q;
	assign length_error   = out_le_q;

	// checks on sequencing and result fields
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input accepted while element still in work");

	a_mean_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mhl_pkg::ST_MEAN) |-> last_q)
		else $error("mean division without last element");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mhl_pkg::ST_FIN && last_q) |-> (acc_q == '0 && elem_q == '0))
		else $error("loss state not cleared after last element");

	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !loss_valid) |-> (mean_loss == '0 && !length_error))
		else $error("loss fields set on non-last result");

endmodule
